FILE: hw/rtl/return_burst_packer_macros.svh
// Assertion macros for the return-link burst packer.
// Included by the top level; ASSERT_OFF removes all checks.
`ifndef RETURN_BURST_PACKER_MACROS_SVH
`define RETURN_BURST_PACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define RBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBP_ASSERT(lbl, clk, rst, prop, msg)
`define RBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/rbp_pkg.sv
// Shared types, codes and helpers for the return-link burst packer.
// No dependencies; used by rbp_core, rbp_skid and return_burst_packer.
package rbp_pkg;

   // Command codes carried on the request tuser.
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_PACKET = 2'd1;
   localparam logic [1:0] CMD_END    = 2'd2;

   // Verdict codes carried on the response tuser.
   localparam logic [2:0] VERDICT_PLACED    = 3'd0;
   localparam logic [2:0] VERDICT_DEFERRED  = 3'd1;
   localparam logic [2:0] VERDICT_DROPPED   = 3'd2;
   localparam logic [2:0] VERDICT_SKIPPED   = 3'd3;
   localparam logic [2:0] VERDICT_REFUSED   = 3'd4;
   localparam logic [2:0] VERDICT_CFG_ERROR = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BURST_LENGTH_BITS = 2'd0;
   localparam logic [1:0] CSR_HEADER_BYTES      = 2'd1;
   localparam logic [1:0] CSR_FRAME_SIZE_MAX    = 2'd2;

   localparam logic [18:0] BURST_LENGTH_BITS_RST = 19'd4096;
   localparam logic [7:0]  HEADER_BYTES_RST      = 8'd4;
   localparam logic [15:0] FRAME_SIZE_MAX_RST    = 16'd1200;

   // Rounding up to kilobits: (x + 999) / 1000 as a multiply by
   // ceil(2^31 / 1000) and a shift. Exact for all 20-bit x.
   localparam int KB_ROUND = 999;
   localparam int KB_RECIP = 2147484;
   localparam int KB_SHIFT = 31;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        frame_closed;
      logic [18:0] closed_frame_bits;
      logic [15:0] frame_count;
      logic [15:0] remaining_kb;
      logic [15:0] packets_in_burst;
   } rbp_result_type;

   function automatic logic [10:0] ceil_kb(input logic [19:0] bits);
      logic [20:0] biased;
      logic [42:0] prod;
      biased = {1'b0, bits} + 21'(KB_ROUND);
      prod   = {22'b0, biased} * 43'(KB_RECIP);
      return prod[KB_SHIFT+10:KB_SHIFT];
   endfunction

endpackage

FILE: hw/rtl/rbp_core.sv
// Burst packing decision logic and superframe state registers.
// Depends on rbp_pkg for codes, the result struct and ceil_kb.
module rbp_core
   import rbp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [18:0]    csr_wdata,
   input  logic           accept,
   input  logic [1:0]     command,
   input  logic [15:0]    allocation_kb,
   input  logic [15:0]    packet_bytes,
   input  logic           random_access,
   output rbp_result_type result
);

   logic [18:0] burst_length_bits_ff;
   logic [7:0]  header_bytes_ff;
   logic [15:0] frame_size_max_ff;

   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] used_bytes_ff, used_bytes_in;
   logic [9:0]  burst_kb_ff, burst_kb_in;   // kilobits the open burst will cost
   logic [15:0] pkt_count_ff, pkt_count_in;
   logic [15:0] emitted_ff, emitted_in;
   logic        stopped_ff, stopped_in;

   logic [15:0] blb_bytes;
   logic        cfg_bad;
   logic [16:0] total_bytes;
   logic [15:0] total_min;
   logic [15:0] capacity;
   logic [15:0] free_bytes;
   logic        over_free;
   logic        burst_open;
   logic        close_pkt;
   logic        drop;
   logic [19:0] sum_bits;
   logic [10:0] need_kb_cont;
   logic [10:0] need_kb_fresh;
   logic [10:0] need_kb;
   logic [15:0] rem_after_close;
   logic [15:0] avail_kb;
   logic        defer;
   logic [15:0] emitted_inc;
   logic [15:0] base_count;

   always_comb begin
      blb_bytes   = burst_length_bits_ff[18:3];
      cfg_bad     = (blb_bytes == 16'd0);
      total_bytes = {1'b0, blb_bytes} + {9'b0, header_bytes_ff};
      total_min   = (total_bytes > {1'b0, frame_size_max_ff}) ? frame_size_max_ff
                                                               : total_bytes[15:0];
      capacity    = (total_min > {8'b0, header_bytes_ff})
                    ? total_min - {8'b0, header_bytes_ff} : 16'd0;
      free_bytes  = (capacity > used_bytes_ff) ? capacity - used_bytes_ff : 16'd0;
      over_free   = (packet_bytes > free_bytes);
      burst_open  = (pkt_count_ff != 16'd0);
      close_pkt   = over_free && burst_open;
      drop        = over_free && (!burst_open || (packet_bytes > capacity));

      // Open burst bits are always eight times the used bytes.
      sum_bits      = {1'b0, used_bytes_ff, 3'b0} + {1'b0, packet_bytes, 3'b0};
      need_kb_cont  = ceil_kb(sum_bits);
      need_kb_fresh = ceil_kb({1'b0, packet_bytes, 3'b0});

      rem_after_close = ({6'b0, burst_kb_ff} >= remaining_ff)
                        ? 16'd0 : remaining_ff - {6'b0, burst_kb_ff};
      // bits > 1000 * rem is the same as ceil(bits / 1000) > rem.
      avail_kb = close_pkt ? rem_after_close : remaining_ff;
      need_kb  = close_pkt ? need_kb_fresh : need_kb_cont;
      defer    = ({5'b0, need_kb} > avail_kb);

      emitted_inc = (emitted_ff != 16'hFFFF) ? emitted_ff + 16'd1 : emitted_ff;
      base_count  = close_pkt ? 16'd0 : pkt_count_ff;
   end

   always_comb begin
      remaining_in  = remaining_ff;
      used_bytes_in = used_bytes_ff;
      burst_kb_in   = burst_kb_ff;
      pkt_count_in  = pkt_count_ff;
      emitted_in    = emitted_ff;
      stopped_in    = stopped_ff;
      result.verdict           = VERDICT_PLACED;
      result.frame_closed      = 1'b0;
      result.closed_frame_bits = 19'd0;

      case (command)
         CMD_START: begin
            remaining_in  = allocation_kb;
            used_bytes_in = 16'd0;
            burst_kb_in   = 10'd0;
            pkt_count_in  = 16'd0;
            emitted_in    = 16'd0;
            stopped_in    = 1'b0;
         end
         CMD_END: begin
            if (burst_open) begin
               result.frame_closed      = 1'b1;
               result.closed_frame_bits = {used_bytes_ff, 3'b0};
               remaining_in  = rem_after_close;
               emitted_in    = emitted_inc;
               used_bytes_in = 16'd0;
               burst_kb_in   = 10'd0;
               pkt_count_in  = 16'd0;
            end
            stopped_in = 1'b1;
         end
         CMD_PACKET: begin
            if (cfg_bad) begin
               result.verdict = VERDICT_CFG_ERROR;
            end else if (stopped_ff || (remaining_ff == 16'd0)) begin
               result.verdict = VERDICT_REFUSED;
               stopped_in     = 1'b1;
            end else if (random_access) begin
               result.verdict = VERDICT_SKIPPED;
            end else begin
               if (close_pkt) begin
                  result.frame_closed      = 1'b1;
                  result.closed_frame_bits = {used_bytes_ff, 3'b0};
                  remaining_in  = rem_after_close;
                  emitted_in    = emitted_inc;
                  used_bytes_in = 16'd0;
                  burst_kb_in   = 10'd0;
                  pkt_count_in  = 16'd0;
               end
               if (drop) begin
                  result.verdict = VERDICT_DROPPED;
               end else if (defer) begin
                  result.verdict = VERDICT_DEFERRED;
                  stopped_in     = 1'b1;
               end else begin
                  result.verdict = VERDICT_PLACED;
                  used_bytes_in  = (close_pkt ? 16'd0 : used_bytes_ff) + packet_bytes;
                  burst_kb_in    = need_kb[9:0];
                  pkt_count_in   = (base_count != 16'hFFFF) ? base_count + 16'd1
                                                            : base_count;
               end
            end
         end
         default: begin
         end
      endcase

      result.frame_count      = emitted_in;
      result.remaining_kb     = remaining_in;
      result.packets_in_burst = pkt_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_length_bits_ff <= BURST_LENGTH_BITS_RST;
         header_bytes_ff      <= HEADER_BYTES_RST;
         frame_size_max_ff    <= FRAME_SIZE_MAX_RST;
         remaining_ff         <= 16'd0;
         used_bytes_ff        <= 16'd0;
         burst_kb_ff          <= 10'd0;
         pkt_count_ff         <= 16'd0;
         emitted_ff           <= 16'd0;
         stopped_ff           <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BURST_LENGTH_BITS: burst_length_bits_ff <= csr_wdata;
               CSR_HEADER_BYTES:      header_bytes_ff      <= csr_wdata[7:0];
               CSR_FRAME_SIZE_MAX:    frame_size_max_ff    <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            remaining_ff  <= remaining_in;
            used_bytes_ff <= used_bytes_in;
            burst_kb_ff   <= burst_kb_in;
            pkt_count_ff  <= pkt_count_in;
            emitted_ff    <= emitted_in;
            stopped_ff    <= stopped_in;
         end
      end
   end

endmodule

FILE: hw/rtl/rbp_skid.sv
// Output register with a skid stage for the result channel.
// Depends on rbp_pkg for the result struct.
module rbp_skid
   import rbp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  rbp_result_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output rbp_result_type out_data
);

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   rbp_result_type out_data_ff, out_data_in;
   rbp_result_type skid_data_ff, skid_data_in;
   logic           take;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign take      = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && !take) begin
         // Output is stalled: park a new transfer in the skid stage.
         if (in_valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = in_valid;
         out_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: hw/rtl/return_burst_packer.sv
// Return-link burst packer: one request per cycle, one response per request.
// Responses are registered (output register, or skid stage on a stall);
// throughput is one request per cycle, limited only by the response side
// draining the two-entry output buffer (output register plus skid stage).
// Synchronous active-high reset clears the superframe state and the output
// buffer and restores the configuration registers to their defaults.
`include "return_burst_packer_macros.svh"
module return_burst_packer
   import rbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [18:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] allocation_kb, [31:16] packet_bytes, [32] random_access
   input  logic [39:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] frame_closed, [19:1] closed_frame_bits, [35:20] frame_count,
   // [51:36] remaining_kb, [67:52] packets_in_burst
   output logic [71:0] rsp_tdata,
   // [2:0] verdict
   output logic [2:0]  rsp_tuser
);

   logic           req_accept;
   rbp_result_type core_res;
   rbp_result_type rsp_res;

   assign req_accept = req_tvalid && req_tready;

   rbp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .accept        (req_accept),
      .command       (req_tuser),
      .allocation_kb (req_tdata[15:0]),
      .packet_bytes  (req_tdata[31:16]),
      .random_access (req_tdata[32]),
      .result        (core_res)
   );

   rbp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_ready  (req_tready),
      .in_data   (core_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   assign rsp_tuser = rsp_res.verdict;
   assign rsp_tdata = {4'b0, rsp_res.packets_in_burst, rsp_res.remaining_kb,
                       rsp_res.frame_count, rsp_res.closed_frame_bits,
                       rsp_res.frame_closed};

   `RBP_ASSERT(a_stall_has_rsp, clock, reset, !req_tready |-> rsp_tvalid,
      "request stalled with no response pending")
   `RBP_ASSERT(a_closed_bits_zero, clock, reset,
      req_accept && !core_res.frame_closed |-> core_res.closed_frame_bits == 19'd0,
      "closed bits set without a closed burst")
   `RBP_ASSERT(a_placed_nonempty, clock, reset,
      req_accept && req_tuser == CMD_PACKET && core_res.verdict == VERDICT_PLACED
      |-> core_res.packets_in_burst != 16'd0,
      "placed packet left burst empty")
   `RBP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid,
      "response valid right after reset")

endmodule
